### rtl/rbf_pkg.sv
// shared types, constants and exp table for the rbf kernel evaluator
`default_nettype none

package rbf_pkg;

    localparam int COORD_SLOTS = 4;
    localparam int DEF_DIMS    = 4;
    localparam int COORD_W     = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int MAG_W       = 17;
    localparam int SD_W        = 20;
    localparam int SQ_W        = 40;
    localparam int SUM_W       = 42;
    localparam int EXP_BITS    = 21;
    localparam int E_W         = 32;
    localparam int OUT_W       = 24;

    localparam logic [CFG_W-1:0] SCALE_ONE = 16'h1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VARIANCE = 3'd0,
        REG_INV_WIDTH = 3'd1,
        REG_SCALE_0 = 3'd2,
        REG_SCALE_1 = 3'd3,
        REG_SCALE_2 = 3'd4,
        REG_SCALE_3 = 3'd5
    } t_reg_idx;

    // round(2^32 * exp(-2^(i-16)))
    localparam logic [E_W-1:0] EXPTAB [EXP_BITS] = '{
        32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
        32'd483
    };

    // exp chain payload: argument, partial product, "still 1.0", "argument out of range"
    typedef struct packed {
        logic [EXP_BITS-1:0] t;
        logic [E_W-1:0]      e;
        logic                one;
        logic                zero;
    } t_exp_bus;

endpackage

`default_nettype wire

### rtl/rbf_kernel_evaluator_core.sv
// top level of the gaussian rbf kernel evaluator with per-dimension scales
`default_nettype none

// Accepts one point pair per cycle while o_ready is high and returns variance * exp(-0.5 *
// inv_width * sum of squared scaled differences) as unsigned Q8.16. The pipeline is made of
// four distance stages, two argument stages, one stage per exp table factor (21 sequential
// 32x32 multiplies) and the output stage with the amplitude multiply. Every stage carries
// its own valid bit, so a held output only stops the stages behind it once they fill up.
// Configuration registers are written on i_cfg_we and read directly by the pipeline;
// write them only while no transfer is in flight.
module rbf_kernel_evaluator_core #(
    parameter int DIMS = rbf_pkg::DEF_DIMS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rbf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rbf_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [rbf_pkg::COORD_W-1:0] i_first_coord_0,
    input  wire logic signed [rbf_pkg::COORD_W-1:0] i_first_coord_1,
    input  wire logic signed [rbf_pkg::COORD_W-1:0] i_first_coord_2,
    input  wire logic signed [rbf_pkg::COORD_W-1:0] i_first_coord_3,
    input  wire logic signed [rbf_pkg::COORD_W-1:0] i_second_coord_0,
    input  wire logic signed [rbf_pkg::COORD_W-1:0] i_second_coord_1,
    input  wire logic signed [rbf_pkg::COORD_W-1:0] i_second_coord_2,
    input  wire logic signed [rbf_pkg::COORD_W-1:0] i_second_coord_3,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [rbf_pkg::OUT_W-1:0]               o_kernel_value
);

    localparam int NE   = rbf_pkg::EXP_BITS;
    localparam int OM_W = rbf_pkg::CFG_W + rbf_pkg::E_W;

    logic [rbf_pkg::CFG_W-1:0] r_variance;
    logic [rbf_pkg::CFG_W-1:0] r_inv_width;
    logic [rbf_pkg::CFG_W-1:0] r_scale [rbf_pkg::COORD_SLOTS];

    logic signed [rbf_pkg::COORD_W-1:0] w_first  [rbf_pkg::COORD_SLOTS];
    logic signed [rbf_pkg::COORD_W-1:0] w_second [rbf_pkg::COORD_SLOTS];

    logic                      w_dist_v;
    logic                      w_dist_rdy;
    logic [rbf_pkg::SUM_W-1:0] w_sum;

    logic              w_exp_v   [NE+1];
    logic              w_exp_rdy [NE+1];
    rbf_pkg::t_exp_bus w_exp_bus [NE+1];

    logic                      w_fin_rdy;
    logic                      w_fin_load;
    logic [OM_W-1:0]           w_omul;
    logic [rbf_pkg::OUT_W-1:0] n_kernel_value;
    logic [rbf_pkg::OUT_W-1:0] r_kernel_value;
    logic                      r_out_v;

    assign w_first[0]  = i_first_coord_0;
    assign w_first[1]  = i_first_coord_1;
    assign w_first[2]  = i_first_coord_2;
    assign w_first[3]  = i_first_coord_3;
    assign w_second[0] = i_second_coord_0;
    assign w_second[1] = i_second_coord_1;
    assign w_second[2] = i_second_coord_2;
    assign w_second[3] = i_second_coord_3;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variance  <= '0;
            r_inv_width <= '0;
            for (int d = 0; d < rbf_pkg::COORD_SLOTS; d++) begin
                r_scale[d] <= rbf_pkg::SCALE_ONE;
            end
        end else if (i_cfg_we) begin
            case (rbf_pkg::t_reg_idx'(i_cfg_idx))
                rbf_pkg::REG_VARIANCE:  r_variance  <= i_cfg_data;
                rbf_pkg::REG_INV_WIDTH: r_inv_width <= i_cfg_data;
                rbf_pkg::REG_SCALE_0:   r_scale[0]  <= i_cfg_data;
                rbf_pkg::REG_SCALE_1:   r_scale[1]  <= i_cfg_data;
                rbf_pkg::REG_SCALE_2:   r_scale[2]  <= i_cfg_data;
                rbf_pkg::REG_SCALE_3:   r_scale[3]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rbf_dist_pipe #(
        .DIMS (DIMS)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_first  (w_first),
        .i_second (w_second),
        .i_scale  (r_scale),
        .o_valid  (w_dist_v),
        .i_ready  (w_dist_rdy),
        .o_sum    (w_sum)
    );

    rbf_arg_pipe u_arg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_dist_v),
        .o_ready     (w_dist_rdy),
        .i_sum       (w_sum),
        .i_inv_width (r_inv_width),
        .o_valid     (w_exp_v[0]),
        .i_ready     (w_exp_rdy[0]),
        .o_bus       (w_exp_bus[0])
    );

    for (genvar i = 0; i < NE; i++) begin : g_exp
        rbf_exp_stage #(
            .IDX (i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_exp_v[i]),
            .o_ready (w_exp_rdy[i]),
            .i_bus   (w_exp_bus[i]),
            .o_valid (w_exp_v[i+1]),
            .i_ready (w_exp_rdy[i+1]),
            .o_bus   (w_exp_bus[i+1])
        );
    end

    // output stage: amplitude multiply and rounding
    assign w_fin_rdy      = !r_out_v || i_ready;
    assign w_exp_rdy[NE]  = w_fin_rdy;
    assign w_fin_load     = w_fin_rdy && w_exp_v[NE];
    assign w_omul         = OM_W'(r_variance) * OM_W'(w_exp_bus[NE].e) + OM_W'(1 << 23);

    always_comb begin
        if (w_exp_bus[NE].zero) begin
            n_kernel_value = '0;
        end else if (w_exp_bus[NE].one) begin
            n_kernel_value = {r_variance, 8'h00};
        end else begin
            n_kernel_value = w_omul[OM_W-1:rbf_pkg::OUT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_fin_rdy) begin
            r_out_v <= w_exp_v[NE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_kernel_value <= n_kernel_value;
        end
    end

    assign o_valid        = r_out_v;
    assign o_kernel_value = r_kernel_value;

    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_load && r_variance == '0) |=> (o_kernel_value == '0))
        else $error("zero amplitude gave a nonzero result");

    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_load && w_exp_bus[NE].zero) |=> (o_kernel_value == '0))
        else $error("argument beyond table range gave a nonzero result");

    a_zero_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_load && w_exp_bus[NE].one && !w_exp_bus[NE].zero)
            |=> (o_kernel_value == {$past(r_variance), 8'h00}))
        else $error("zero argument did not return the amplitude");

endmodule

`default_nettype wire

### rtl/rbf_dist_pipe.sv
// scaled squared distance: difference, scaling, squaring and sum over four stages
`default_nettype none

module rbf_dist_pipe #(
    parameter int DIMS = rbf_pkg::DEF_DIMS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [rbf_pkg::COORD_W-1:0]  i_first  [rbf_pkg::COORD_SLOTS],
    input  wire logic signed [rbf_pkg::COORD_W-1:0]  i_second [rbf_pkg::COORD_SLOTS],
    input  wire logic        [rbf_pkg::CFG_W-1:0]    i_scale  [rbf_pkg::COORD_SLOTS],
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic             [rbf_pkg::SUM_W-1:0]    o_sum
);

    localparam int NL = (DIMS > rbf_pkg::COORD_SLOTS) ? rbf_pkg::COORD_SLOTS : DIMS;
    localparam int NS = 4;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    logic [rbf_pkg::MAG_W-1:0] r_m  [NL];
    logic [rbf_pkg::MAG_W-1:0] n_m  [NL];
    logic [rbf_pkg::SD_W-1:0]  r_s  [NL];
    logic [rbf_pkg::SD_W-1:0]  n_s  [NL];
    logic [rbf_pkg::SQ_W-1:0]  r_sq [NL];
    logic [rbf_pkg::SQ_W-1:0]  n_sq [NL];
    logic [rbf_pkg::SUM_W-1:0] r_sum;
    logic [rbf_pkg::SUM_W-1:0] n_sum;

    assign w_rdy[NS] = i_ready;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_sum   = r_sum;

    always_comb begin
        logic [rbf_pkg::MAG_W-1:0] diff;
        logic [32:0]               prod;
        for (int d = 0; d < NL; d++) begin
            diff    = {i_first[d][rbf_pkg::COORD_W-1], i_first[d]}
                    - {i_second[d][rbf_pkg::COORD_W-1], i_second[d]};
            n_m[d]  = diff[rbf_pkg::MAG_W-1] ? (~diff + 17'd1) : diff;
            prod    = 33'(r_m[d]) * 33'(i_scale[d]) + 33'd2048;
            n_s[d]  = prod[31:12];
            n_sq[d] = 40'(r_s[d]) * 40'(r_s[d]);
        end
        n_sum = '0;
        for (int d = 0; d < NL; d++) begin
            n_sum = n_sum + rbf_pkg::SUM_W'(r_sq[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < NL; d++) begin
            if (w_rdy[0] && i_valid) begin
                r_m[d] <= n_m[d];
            end
            if (w_rdy[1] && r_v[0]) begin
                r_s[d] <= n_s[d];
            end
            if (w_rdy[2] && r_v[1]) begin
                r_sq[d] <= n_sq[d];
            end
        end
        if (w_rdy[3] && r_v[2]) begin
            r_sum <= n_sum;
        end
    end

endmodule

`default_nettype wire

### rtl/rbf_arg_pipe.sv
// exp argument: half inverse width times distance, rounded, with range check
`default_nettype none

module rbf_arg_pipe (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [rbf_pkg::SUM_W-1:0]        i_sum,
    input  wire logic [rbf_pkg::CFG_W-1:0]        i_inv_width,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output rbf_pkg::t_exp_bus                     o_bus
);

    localparam int HALF_W = rbf_pkg::SUM_W / 2;
    localparam int PP_W   = HALF_W + rbf_pkg::CFG_W;
    localparam int ACC_W  = rbf_pkg::SUM_W + rbf_pkg::CFG_W;

    logic [1:0] r_v;
    logic [2:0] w_rdy;

    logic [PP_W-1:0]   r_lo;
    logic [PP_W-1:0]   r_hi;
    logic [PP_W-1:0]   n_lo;
    logic [PP_W-1:0]   n_hi;
    logic [ACC_W-1:0]  w_acc;
    rbf_pkg::t_exp_bus r_bus;
    rbf_pkg::t_exp_bus n_bus;

    assign w_rdy[2] = i_ready;
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[1];
    assign o_bus    = r_bus;

    assign n_lo  = PP_W'(i_sum[HALF_W-1:0]) * PP_W'(i_inv_width);
    assign n_hi  = PP_W'(i_sum[rbf_pkg::SUM_W-1:HALF_W]) * PP_W'(i_inv_width);
    assign w_acc = {r_hi, {HALF_W{1'b0}}} + ACC_W'(r_lo) + ACC_W'(1 << 16);

    always_comb begin
        n_bus      = '0;
        n_bus.t    = w_acc[17 +: rbf_pkg::EXP_BITS];
        n_bus.one  = 1'b1;
        n_bus.zero = |w_acc[ACC_W-1:17+rbf_pkg::EXP_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_v[1] <= r_v[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (w_rdy[1] && r_v[0]) begin
            r_bus <= n_bus;
        end
    end

endmodule

`default_nettype wire

### rtl/rbf_exp_stage.sv
// one exp chain stage: multiply by the table factor for one argument bit
`default_nettype none

module rbf_exp_stage #(
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire rbf_pkg::t_exp_bus i_bus,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output rbf_pkg::t_exp_bus      o_bus
);

    localparam int PW = 2 * rbf_pkg::E_W;

    logic                    r_v;
    rbf_pkg::t_exp_bus       r_bus;
    rbf_pkg::t_exp_bus       n_bus;
    logic [rbf_pkg::E_W-1:0] w_coef;
    logic [PW-1:0]           w_prod;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_bus   = r_bus;

    assign w_coef = rbf_pkg::EXPTAB[IDX];
    assign w_prod = PW'(i_bus.e) * PW'(w_coef) + PW'(64'h8000_0000);

    always_comb begin
        n_bus = i_bus;
        if (i_bus.t[IDX] && !i_bus.zero) begin
            n_bus.one = 1'b0;
            if (i_bus.one) begin
                n_bus.e = w_coef;
            end else begin
                n_bus.e = w_prod[PW-1:rbf_pkg::E_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bus <= n_bus;
        end
    end

endmodule

`default_nettype wire

### test/rbf_kernel_evaluator_core_test.sv
// self-checking testbench for the rbf kernel evaluator core: directed, random and stall traffic
`default_nettype none

module rbf_kernel_evaluator_core_test;

    import rbf_pkg::*;

    localparam int IDLE_MAX     = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [E_W-1:0] NEG_EXP_FACTOR [EXP_BITS] = '{
        32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
        32'd483
    };

    typedef struct packed {
        logic [COORD_SLOTS-1:0][COORD_W-1:0] first;
        logic [COORD_SLOTS-1:0][COORD_W-1:0] second;
    } t_point_pair;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [COORD_W-1:0]   i_first_coord_0;
    logic [COORD_W-1:0]   i_first_coord_1;
    logic [COORD_W-1:0]   i_first_coord_2;
    logic [COORD_W-1:0]   i_first_coord_3;
    logic [COORD_W-1:0]   i_second_coord_0;
    logic [COORD_W-1:0]   i_second_coord_1;
    logic [COORD_W-1:0]   i_second_coord_2;
    logic [COORD_W-1:0]   i_second_coord_3;
    logic                 o_valid;
    logic                 i_ready;
    logic [OUT_W-1:0]     o_kernel_value;

    // register mirror used by the predictor
    logic [CFG_W-1:0] cfg_gain;
    logic [CFG_W-1:0] cfg_inv_width;
    logic [CFG_W-1:0] cfg_scale [COORD_SLOTS];

    logic [OUT_W-1:0] pending_kernel_q [$];
    logic [OUT_W-1:0] kernel_expected;

    int  cycle_count;
    int  fail_count;
    int  pairs_sent;
    int  kernels_checked;
    int  input_stall_cycles;
    int  hold_request;
    int  hold_left;
    int  sink_wait;
    bit  src_calm;
    bit  sink_calm;

    rbf_kernel_evaluator_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_first_coord_0  (i_first_coord_0),
        .i_first_coord_1  (i_first_coord_1),
        .i_first_coord_2  (i_first_coord_2),
        .i_first_coord_3  (i_first_coord_3),
        .i_second_coord_0 (i_second_coord_0),
        .i_second_coord_1 (i_second_coord_1),
        .i_second_coord_2 (i_second_coord_2),
        .i_second_coord_3 (i_second_coord_3),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kernel_value   (o_kernel_value)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rbf_kernel_evaluator_core_test failed");
            $finish;
        end
    end

    // variance * exp(-0.5 * inv_width * sum of squared scaled differences)
    function automatic logic [OUT_W-1:0] rbf_kernel_of(t_point_pair p);
        logic signed [MAG_W-1:0] diff;
        logic [MAG_W-1:0]        mag;
        logic [63:0]             scaled;
        logic [63:0]             sum;
        logic [63:0]             arg;
        logic [63:0]             e;
        logic [63:0]             r;
        sum = '0;
        for (int d = 0; d < COORD_SLOTS; d++) begin
            diff   = $signed(p.first[d]) - $signed(p.second[d]);
            mag    = diff[MAG_W-1] ? -diff : diff;
            scaled = (64'(mag) * 64'(cfg_scale[d]) + 64'd2048) >> 12;
            sum    = sum + scaled * scaled;
        end
        arg = (sum * 64'(cfg_inv_width) + 64'h1_0000) >> 17;
        if (arg >= (64'd1 << EXP_BITS)) begin
            e = '0;
        end else begin
            e = 64'd1 << 32;
            for (int i = 0; i < EXP_BITS; i++) begin
                if (arg[i]) begin
                    e = (e * 64'(NEG_EXP_FACTOR[i]) + 64'h8000_0000) >> 32;
                end
            end
        end
        r = (64'(cfg_gain) * e + 64'h80_0000) >> 24;
        if (r > 64'hFF_FFFF) begin
            r = 64'hFF_FFFF;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic int idle_draw(bit calm);
        return calm ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic t_point_pair uniform_pair(logic [COORD_W-1:0] f, logic [COORD_W-1:0] s);
        t_point_pair p;
        for (int d = 0; d < COORD_SLOTS; d++) begin
            p.first[d]  = f;
            p.second[d] = s;
        end
        return p;
    endfunction

    function automatic t_point_pair one_dim_pair(int dim, logic [COORD_W-1:0] f,
                                                 logic [COORD_W-1:0] s);
        t_point_pair p;
        p = uniform_pair('0, '0);
        p.first[dim]  = f;
        p.second[dim] = s;
        return p;
    endfunction

    // half the pairs nearby so the exp argument tends to land in range, the rest wide or edge pairs
    function automatic t_point_pair random_pair();
        t_point_pair        p;
        int                 kind;
        int                 w;
        logic [COORD_W-1:0] delta;
        logic [COORD_W-1:0] edges [5];
        edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        kind  = $urandom_range(0, 3);
        for (int d = 0; d < COORD_SLOTS; d++) begin
            p.first[d] = COORD_W'($urandom);
            case (kind)
                0, 1: begin
                    w     = $urandom_range(0, COORD_W);
                    delta = COORD_W'($urandom & ((32'd1 << w) - 1));
                    p.second[d] = $urandom_range(0, 1) ? p.first[d] + delta : p.first[d] - delta;
                end
                2: begin
                    p.second[d] = COORD_W'($urandom);
                end
                default: begin
                    p.first[d]  = edges[$urandom_range(0, 4)];
                    p.second[d] = edges[$urandom_range(0, 4)];
                end
            endcase
        end
        return p;
    endfunction

    function automatic logic [CFG_W-1:0] spread_value();
        return CFG_W'($urandom >> $urandom_range(16, 31));
    endfunction

    task automatic send_pair(t_point_pair p);
        int gap;
        gap = idle_draw(src_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_first_coord_0  <= p.first[0];
        i_first_coord_1  <= p.first[1];
        i_first_coord_2  <= p.first[2];
        i_first_coord_3  <= p.first[3];
        i_second_coord_0 <= p.second[0];
        i_second_coord_1 <= p.second[1];
        i_second_coord_2 <= p.second[2];
        i_second_coord_3 <= p.second[3];
        @(posedge i_clk);
        while (!o_ready) begin
            input_stall_cycles++;
            @(posedge i_clk);
        end
        pending_kernel_q.push_back(rbf_kernel_of(p));
        pairs_sent++;
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (pending_kernel_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_VARIANCE:  cfg_gain      = value;
            REG_INV_WIDTH: cfg_inv_width = value;
            REG_SCALE_0:   cfg_scale[0]  = value;
            REG_SCALE_1:   cfg_scale[1]  = value;
            REG_SCALE_2:   cfg_scale[2]  = value;
            REG_SCALE_3:   cfg_scale[3]  = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [CFG_W-1:0] gain, logic [CFG_W-1:0] inv_width,
                              logic [COORD_SLOTS-1:0][CFG_W-1:0] scales);
        wait_results_done();
        write_reg(REG_VARIANCE, gain);
        write_reg(REG_INV_WIDTH, inv_width);
        for (int d = 0; d < COORD_SLOTS; d++) begin
            write_reg(CFG_IDX_W'(REG_SCALE_0 + d), scales[d]);
        end
    endtask

    task automatic send_random_pairs(int count);
        for (int n = 0; n < count; n++) begin
            send_pair(random_pair());
        end
    endtask

    // zero gain after reset, then unit scales left at their reset value
    task automatic test_reset_values();
        send_pair(uniform_pair('0, '0));
        send_pair(uniform_pair(16'h7FFF, 16'h8000));
        send_pair(random_pair());
        wait_results_done();
        write_reg(REG_VARIANCE, 16'h4000);
        write_reg(REG_INV_WIDTH, 16'h0100);
        send_pair(uniform_pair('0, '0));
        send_pair(one_dim_pair(1, 16'h0400, 16'hFC00));
        send_pair(random_pair());
    endtask

    task automatic test_directed_extremes();
        set_config(16'hFFFF, 16'h0100, {4{SCALE_ONE}});
        send_pair(uniform_pair('0, '0));
        send_pair(uniform_pair(16'h7FFF, 16'h8000));
        send_pair(uniform_pair(16'h8000, 16'h7FFF));
        send_pair(uniform_pair(16'h1234, 16'h1234));
        for (int d = 0; d < COORD_SLOTS; d++) begin
            send_pair(one_dim_pair(d, 16'h0001, 16'h0000));
        end
        // exp argument just past and just inside the table range
        send_pair(one_dim_pair(0, 16'h4000, 16'hC000));
        send_pair(one_dim_pair(1, 16'h3FFF, 16'hC000));
        send_pair(one_dim_pair(2, 16'hFFFB, 16'h0003));
        set_config(16'hFFFF, 16'hFFFF, {4{SCALE_ONE}});
        send_pair(one_dim_pair(3, 16'h0001, 16'h0000));
        send_pair(uniform_pair(16'h0002, 16'h0000));
        set_config(16'hFFFF, 16'hFFFF, {4{16'h0000}});
        send_pair(uniform_pair(16'h7FFF, 16'h8000));
        set_config(16'hFFFF, 16'h0001, {4{16'hFFFF}});
        send_pair(one_dim_pair(0, 16'h0001, 16'h0000));
        send_pair(uniform_pair(16'h7FFF, 16'h8000));
    endtask

    // writes above the last register index leave every register alone
    task automatic test_spare_index();
        set_config(16'h1357, 16'h0040, {16'h1000, 16'h0800, 16'h2000, 16'h1800});
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        send_pair(uniform_pair('0, '0));
        send_pair(one_dim_pair(2, 16'h0100, 16'h0000));
        send_random_pairs(4);
    endtask

    task automatic test_register_sweep();
        set_config(16'h0000, 16'h0000, {4{16'h0000}});
        send_random_pairs(30);
        set_config(16'hFFFF, 16'h0000, {4{16'hFFFF}});
        send_random_pairs(30);
        set_config(16'hFFFF, 16'hFFFF, {4{16'hFFFF}});
        send_random_pairs(30);
        set_config(16'h8001, 16'h0001, {16'h0001, 16'hFFFF, 16'h0000, 16'h1000});
        send_random_pairs(30);
        for (int k = 0; k < 3; k++) begin
            set_config(CFG_W'($urandom), spread_value(),
                       {spread_value(), spread_value(), spread_value(), spread_value()});
            send_random_pairs(40);
        end
    endtask

    task automatic test_random_stream();
        for (int block = 0; block < 4; block++) begin
            set_config(CFG_W'($urandom), spread_value(),
                       {spread_value(), spread_value(), spread_value(), spread_value()});
            for (int part = 0; part < 2; part++) begin
                src_calm  = ($urandom_range(0, 3) == 0);
                sink_calm = ($urandom_range(0, 3) == 0);
                send_random_pairs(40);
            end
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    // receiver holds off while pairs keep coming, so the pipeline fills and stalls its input
    task automatic test_backpressure();
        set_config(16'hC000, 16'h0200, {16'h1000, 16'h0C00, 16'h1400, 16'h0800});
        src_calm     = 1'b1;
        hold_request = LONG_HOLD;
        send_random_pairs(80);
        wait_results_done();
        src_calm = 1'b0;
    endtask

    task automatic test_full_rate();
        src_calm  = 1'b1;
        sink_calm = 1'b1;
        send_random_pairs(60);
        wait_results_done();
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_kernel_q.size() == 0) begin
                $error("kernel_value transfer with nothing expected: actual %0d", o_kernel_value);
                fail_count++;
            end else begin
                kernel_expected = pending_kernel_q.pop_front();
                kernels_checked++;
                if (o_kernel_value !== kernel_expected) begin
                    $error("kernel_value mismatch: expected %0d, actual %0d",
                           kernel_expected, o_kernel_value);
                    fail_count++;
                end
            end
            sink_wait = idle_draw(sink_calm);
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        i_valid            = 1'b0;
        i_ready            = 1'b0;
        i_first_coord_0    = '0;
        i_first_coord_1    = '0;
        i_first_coord_2    = '0;
        i_first_coord_3    = '0;
        i_second_coord_0   = '0;
        i_second_coord_1   = '0;
        i_second_coord_2   = '0;
        i_second_coord_3   = '0;
        cycle_count        = 0;
        fail_count         = 0;
        pairs_sent         = 0;
        kernels_checked    = 0;
        input_stall_cycles = 0;
        hold_request       = 0;
        hold_left          = 0;
        sink_wait          = 0;
        src_calm           = 1'b0;
        sink_calm          = 1'b0;
        cfg_gain           = '0;
        cfg_inv_width      = '0;
        for (int d = 0; d < COORD_SLOTS; d++) begin
            cfg_scale[d] = SCALE_ONE;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed_extremes();
        test_spare_index();
        test_register_sweep();
        test_random_stream();
        test_backpressure();
        test_full_rate();

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d point pairs over reset, extreme, swept and random register settings",
                 pairs_sent);
        $display("checked %0d kernel values, input stalled for %0d cycles under back-pressure",
                 kernels_checked, input_stall_cycles);
        if (fail_count == 0 && pending_kernel_q.size() == 0) begin
            $display("rbf_kernel_evaluator_core_test passed");
        end else begin
            $display("rbf_kernel_evaluator_core_test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/rbf_pkg.sv
rtl/rbf_dist_pipe.sv
rtl/rbf_arg_pipe.sv
rtl/rbf_exp_stage.sv
rtl/rbf_kernel_evaluator_core.sv
test/rbf_kernel_evaluator_core_test.sv
